// ===== hw/rtl/gtsg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Gated two-tone stimulus generator package
// Shared constants, register indexes and the quarter-wave sine table builder.
// ----------------------------------------------------------------------------
package gtsg_pkg;

   localparam int unsigned PHASE_BITS_DEF      = 32;
   localparam int unsigned SINE_TABLE_BITS_DEF = 10;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned STEP_W      = 32;
   localparam int unsigned GAIN_W      = 15;
   localparam int unsigned LEN_W       = 20;
   localparam int unsigned SAMPLE_W    = 16;
   localparam int unsigned TAB_W       = 15;

   localparam logic [LEN_W-1:0] BURST_LENGTH_RST = LEN_W'(44100);
   localparam int unsigned      FULL_SCALE       = 32767;
   localparam logic [63:0]      HALF_PI_Q30      = 64'd1686629713;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE         = 3'd0,
      CSR_MASKER_STEP  = 3'd1,
      CSR_MASKER_GAIN  = 3'd2,
      CSR_PROBE_STEP   = 3'd3,
      CSR_PROBE_GAIN   = 3'd4,
      CSR_BURST_LENGTH = 3'd5
   } csr_index_type;

   // Magnitude of one quarter-wave table entry in Q15, built from a Q30 Taylor series.
   function automatic logic [TAB_W-1:0] quarter_sine(input int unsigned r,
                                                     input int unsigned qtr_bits);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        mag;
      logic signed [63:0] sum;
      logic signed [63:0] q15;
      x   = (64'(r) * HALF_PI_Q30) >> qtr_bits;
      x2  = (x * x) >> 30;
      mag = x;
      sum = $signed(x);
      mag = ((mag * x2) >> 30) / 64'd6;
      sum = sum - $signed(mag);
      mag = ((mag * x2) >> 30) / 64'd20;
      sum = sum + $signed(mag);
      mag = ((mag * x2) >> 30) / 64'd42;
      sum = sum - $signed(mag);
      mag = ((mag * x2) >> 30) / 64'd72;
      sum = sum + $signed(mag);
      mag = ((mag * x2) >> 30) / 64'd110;
      sum = sum - $signed(mag);
      mag = ((mag * x2) >> 30) / 64'd156;
      sum = sum + $signed(mag);
      if (sum < 0) begin
         sum = 64'sd0;
      end
      q15 = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
      if (q15 > 64'sd32767) begin
         q15 = 64'sd32767;
      end
      return q15[TAB_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/gated_two_tone_stimulus_generator_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Gated two-tone stimulus generator
// A five-register pipeline carries each request's sample to the result channel.
// Throughput: one request and one sample per cycle while the result side is not stalled.
// The quarter-wave sine table is read in the second stage, the gain products in the third.
// Reset clears the burst position, both phases, the pipeline valid flags and the
// configuration registers, with the burst length returning to 44100.
// ----------------------------------------------------------------------------
module gated_two_tone_stimulus_generator_top #(
   parameter int unsigned PHASE_BITS      = gtsg_pkg::PHASE_BITS_DEF,
   parameter int unsigned SINE_TABLE_BITS = gtsg_pkg::SINE_TABLE_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [gtsg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [gtsg_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_restart,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [gtsg_pkg::SAMPLE_W-1:0]    rsp_sample,
   output logic                                    rsp_last
);

   localparam int unsigned QTR_BITS = SINE_TABLE_BITS - 2;
   localparam int unsigned QTR_SIZE = 1 << QTR_BITS;
   localparam int unsigned IDX_W    = QTR_BITS + 1;
   localparam int unsigned LEN_W    = gtsg_pkg::LEN_W;
   localparam int unsigned GAIN_W   = gtsg_pkg::GAIN_W;
   localparam int unsigned TAB_W    = gtsg_pkg::TAB_W;
   localparam int unsigned SW       = gtsg_pkg::SAMPLE_W;
   localparam int unsigned STAGES   = 5;

   logic                      mode_ff;
   logic [gtsg_pkg::STEP_W-1:0] masker_step_ff;
   logic [GAIN_W-1:0]         masker_gain_ff;
   logic [gtsg_pkg::STEP_W-1:0] probe_step_ff;
   logic [GAIN_W-1:0]         probe_gain_ff;
   logic [LEN_W-1:0]          burst_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= 1'b0;
         masker_step_ff  <= '0;
         masker_gain_ff  <= '0;
         probe_step_ff   <= '0;
         probe_gain_ff   <= '0;
         burst_length_ff <= gtsg_pkg::BURST_LENGTH_RST;
      end else if (csr_we) begin
         case (csr_index)
            gtsg_pkg::CSR_MODE:         mode_ff         <= csr_wdata[0];
            gtsg_pkg::CSR_MASKER_STEP:  masker_step_ff  <= csr_wdata;
            gtsg_pkg::CSR_MASKER_GAIN:  masker_gain_ff  <= csr_wdata[GAIN_W-1:0];
            gtsg_pkg::CSR_PROBE_STEP:   probe_step_ff   <= csr_wdata;
            gtsg_pkg::CSR_PROBE_GAIN:   probe_gain_ff   <= csr_wdata[GAIN_W-1:0];
            gtsg_pkg::CSR_BURST_LENGTH: burst_length_ff <= csr_wdata[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Pipeline flow control.
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] stage_ready;
   logic [STAGES-1:0] load;
   logic              req_xfer;

   always_comb begin
      stage_ready[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
      for (int i = STAGES - 2; i >= 0; i--) begin
         stage_ready[i] = !valid_ff[i] || stage_ready[i+1];
      end
      load[0]     = stage_ready[0] && req_valid;
      valid_in[0] = stage_ready[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         load[i]     = stage_ready[i] && valid_ff[i-1];
         valid_in[i] = stage_ready[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   assign req_xfer  = load[0];
   assign req_stall = !stage_ready[0];
   assign rsp_valid = valid_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Burst state and address stage.
   logic [LEN_W-1:0]      index_ff, index_in;
   logic [PHASE_BITS-1:0] m_phase_ff, m_phase_in;
   logic [PHASE_BITS-1:0] p_phase_ff, p_phase_in;
   logic [LEN_W-1:0]      cur_n;
   logic [PHASE_BITS-1:0] cur_m_phase;
   logic [PHASE_BITS-1:0] cur_p_phase;
   logic [LEN_W+1:0]      len_x3;
   logic                  probe_on;
   logic                  last_now;
   logic [SINE_TABLE_BITS-1:0] m_addr, p_addr;
   logic [IDX_W-1:0]      m_idx_in, p_idx_in;

   always_comb begin
      cur_n       = req_restart ? '0 : index_ff;
      cur_m_phase = req_restart ? '0 : m_phase_ff;
      cur_p_phase = req_restart ? '0 : p_phase_ff;
      len_x3      = {2'b00, burst_length_ff} + {1'b0, burst_length_ff, 1'b0};
      probe_on    = !mode_ff || (cur_n < (burst_length_ff >> 2)) ||
                    ((cur_n >= (burst_length_ff >> 1)) && (cur_n < len_x3[LEN_W+1:2]));
      last_now    = ({1'b0, cur_n} + (LEN_W+1)'(1)) >= {1'b0, burst_length_ff};
      if (last_now) begin
         index_in   = '0;
         m_phase_in = '0;
         p_phase_in = '0;
      end else begin
         index_in   = cur_n + LEN_W'(1);
         m_phase_in = cur_m_phase + PHASE_BITS'(masker_step_ff);
         p_phase_in = cur_p_phase + PHASE_BITS'(probe_step_ff);
      end
      m_addr   = cur_m_phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
      p_addr   = cur_p_phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
      m_idx_in = m_addr[SINE_TABLE_BITS-2] ?
                 IDX_W'(QTR_SIZE) - {1'b0, m_addr[QTR_BITS-1:0]} :
                 {1'b0, m_addr[QTR_BITS-1:0]};
      p_idx_in = p_addr[SINE_TABLE_BITS-2] ?
                 IDX_W'(QTR_SIZE) - {1'b0, p_addr[QTR_BITS-1:0]} :
                 {1'b0, p_addr[QTR_BITS-1:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff   <= '0;
         m_phase_ff <= '0;
         p_phase_ff <= '0;
      end else if (req_xfer) begin
         index_ff   <= index_in;
         m_phase_ff <= m_phase_in;
         p_phase_ff <= p_phase_in;
      end
   end

   logic [IDX_W-1:0] m_idx_ff, p_idx_ff;
   logic             m_neg_ff, p_neg_ff, m_on_ff, p_on_ff, last0_ff;

   always_ff @(posedge clock) begin
      if (load[0]) begin
         m_idx_ff <= m_idx_in;
         p_idx_ff <= p_idx_in;
         m_neg_ff <= m_addr[SINE_TABLE_BITS-1];
         p_neg_ff <= p_addr[SINE_TABLE_BITS-1];
         m_on_ff  <= mode_ff;
         p_on_ff  <= probe_on;
         last0_ff <= last_now;
      end
   end

   // Quarter-wave table lookup stage.
   logic [TAB_W-1:0] rom [0:QTR_SIZE];

   for (genvar k = 0; k <= QTR_SIZE; k++) begin : g_rom
      localparam logic [TAB_W-1:0] ENTRY = gtsg_pkg::quarter_sine(k, QTR_BITS);
      assign rom[k] = ENTRY;
   end

   logic signed [SW-1:0] m_val_in, p_val_in, m_val_ff, p_val_ff;
   logic [TAB_W-1:0]     m_tab, p_tab;
   logic                 last1_ff;

   always_comb begin
      m_tab    = rom[m_idx_ff];
      p_tab    = rom[p_idx_ff];
      m_val_in = m_neg_ff ? -$signed({1'b0, m_tab}) : $signed({1'b0, m_tab});
      p_val_in = p_neg_ff ? -$signed({1'b0, p_tab}) : $signed({1'b0, p_tab});
      if (!m_on_ff) begin
         m_val_in = '0;
      end
      if (!p_on_ff) begin
         p_val_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         m_val_ff <= m_val_in;
         p_val_ff <= p_val_in;
         last1_ff <= last0_ff;
      end
   end

   // Gain stage.
   logic signed [2*SW-1:0] m_prod_ff, p_prod_ff;
   logic                   last2_ff;

   always_ff @(posedge clock) begin
      if (load[2]) begin
         m_prod_ff <= $signed({1'b0, masker_gain_ff}) * m_val_ff;
         p_prod_ff <= $signed({1'b0, probe_gain_ff}) * p_val_ff;
         last2_ff  <= last1_ff;
      end
   end

   // Sum and magnitude stage.
   logic signed [2*SW-1:0] sum;
   logic [2*SW-1:0]        mag_full;
   logic [2*SW-2:0]        mag_ff;
   logic                   neg_ff, last3_ff;

   always_comb begin
      sum      = m_prod_ff + p_prod_ff;
      mag_full = sum[2*SW-1] ? (2*SW)'(-sum) : (2*SW)'(sum);
   end

   always_ff @(posedge clock) begin
      if (load[3]) begin
         mag_ff   <= mag_full[2*SW-2:0];
         neg_ff   <= sum[2*SW-1];
         last3_ff <= last2_ff;
      end
   end

   // Divide by full scale and saturate: quotient by 2^15 plus up to three corrections.
   logic [SW-1:0]        q_base;
   logic [SW:0]          rem;
   logic [SW:0]          quot;
   logic [1:0]           corr;
   logic signed [SW-1:0] sample_in;
   logic signed [SW-1:0] rsp_sample_ff;
   logic                 rsp_last_ff;

   always_comb begin
      q_base = mag_ff[2*SW-2:SW-1];
      rem    = {2'b00, mag_ff[SW-2:0]} + {1'b0, q_base};
      corr   = 2'(rem >= (SW+1)'(gtsg_pkg::FULL_SCALE)) +
               2'(rem >= (SW+1)'(2 * gtsg_pkg::FULL_SCALE)) +
               2'(rem >= (SW+1)'(3 * gtsg_pkg::FULL_SCALE));
      quot   = {1'b0, q_base} + (SW+1)'(corr);
      if (neg_ff) begin
         if (quot >= (SW+1)'(1 << (SW - 1))) begin
            sample_in = {1'b1, {(SW-1){1'b0}}};
         end else begin
            sample_in = -$signed(quot[SW-1:0]);
         end
      end else begin
         if (quot >= (SW+1)'((1 << (SW - 1)) - 1)) begin
            sample_in = {1'b0, {(SW-1){1'b1}}};
         end else begin
            sample_in = $signed(quot[SW-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[4]) begin
         rsp_sample_ff <= sample_in;
         rsp_last_ff   <= last3_ff;
      end
   end

   assign rsp_sample = rsp_sample_ff;
   assign rsp_last   = rsp_last_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/gtsg_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Gated two-tone stimulus generator checker
// Port-level assertions on flow control and pipeline timing, bound to the top level.
// ----------------------------------------------------------------------------
module gtsg_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_stall,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic signed [gtsg_pkg::SAMPLE_W-1:0] rsp_sample,
   input wire logic                                rsp_last
);

   // A stalled result holds its valid and its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample) && $stable(rsp_last))
      else $error("result changed while stalled");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Requests are held off only when every stage is full behind a stalled result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled result");

   // With the result side free, an accepted request reaches the output through the pipeline registers.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
      |=> rsp_valid)
      else $error("result did not arrive in time");

endmodule

bind gated_two_tone_stimulus_generator_top gtsg_checker u_gtsg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_sample (rsp_sample),
   .rsp_last   (rsp_last)
);
`default_nettype wire
